// ===== rtl/core/urde_pkg.sv =====
// ----------------------------------------------------------------------------
// urde_pkg
// Shared types, codes and the CRC-8 byte update for the UART register
// datagram engine.
// ----------------------------------------------------------------------------
package urde_pkg;

    // Input opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_RX     = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Command kinds carried through the queue
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // Result kinds
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Datagram constants
    localparam logic [7:0]  SYNC_BYTE  = 8'h05;
    localparam logic [7:0]  CRC_POLY   = 8'h07;
    localparam logic [7:0]  WRITE_FLAG = 8'h80;
    localparam logic [31:0] ERROR_WORD = 32'hFFFF_FFFF;

    // Byte index of the CRC byte in each frame, last reply byte index
    localparam logic [2:0] WRITE_CRC_IDX = 3'd7;
    localparam logic [2:0] READ_CRC_IDX  = 3'd3;
    localparam logic [2:0] REPLY_LAST    = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  reg_addr;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_data;
        logic        crc_error;
    } out_item_t;

    // Classified command: data holds write data, or the received byte in [7:0]
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  node_addr;
        logic [7:0]  reg_byte;
        logic [31:0] data;
    } cmd_t;

    // Queue status toward the rest of the block
    typedef struct packed {
        logic       full;
        logic       valid;
        logic [1:0] count;
    } q_stat_t;

    // Back-end status
    typedef struct packed {
        logic [2:0] frame_idx;
        logic [2:0] reply_count;
    } back_stat_t;

    // CRC-8, poly 0x07, byte fed LSB first, register shifts left
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7] ^ data[i])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/uart_register_datagram_engine_top.sv =====
// Frames: a write request becomes eight bytes, a read request four; the back end's
//   byte serializer emits one result per cycle while a command is queued and out_stall is low.
// Path: an accepted input is first written into the queue, and the output register
//   is then loaded from the queue head. A 2-entry queue lets input run ahead.
// Reset: rst_n asynchronous, active low; clears queue, frame and reply state,
//   and the node address to 0.
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_top
// Master side of a UART register datagram link with CRC-8: builds write and
// read request frames and checks eight-byte replies.
// ----------------------------------------------------------------------------
module uart_register_datagram_engine_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  urde_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output urde_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import urde_pkg::*;

    logic       q_push;
    cmd_t       q_push_cmd;
    logic       q_pop;
    cmd_t       q_head_cmd;
    q_stat_t    q_stat;
    back_stat_t b_stat;

    // Front: accept and classify
    urde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // Command queue
    urde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .stat     (q_stat)
    );

    // Back: frame serializer and reply checker
    urde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_stat.valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .stat       (b_stat)
    );

`ifndef SYNTHESIS
    // A frame in progress keeps its request at the queue head
    a_frame_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (b_stat.frame_idx != 3'd0) |-> (q_stat.valid && (q_head_cmd.kind != CMD_RX)))
        else $error("frame in progress without a request at queue head");

    // Front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_push)
        else $error("push into full queue");

    // A popped last frame byte returns the serializer to its start
    a_pop_resets_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_head_cmd.kind != CMD_RX)) |=> (b_stat.frame_idx == 3'd0))
        else $error("frame index not cleared after frame end");

    // Reply results are final and carry the error word on a CRC error
    a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.crc_error) |->
            (out_data.last && (out_data.read_data == ERROR_WORD)
             && (out_data.result_kind == KIND_REPLY)))
        else $error("malformed error reply");
`endif

endmodule

// ===== rtl/core/urde_front.sv =====
// ----------------------------------------------------------------------------
// urde_front
// Accepts input requests, classifies them by opcode and pushes a command
// into the queue. Holds the node address register.
// ----------------------------------------------------------------------------
module urde_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  urde_pkg::in_item_t in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    input  urde_pkg::q_stat_t q_stat,
    output logic              q_push,
    output urde_pkg::cmd_t    q_cmd
);
    import urde_pkg::*;

    logic [7:0] node_address_reg;
    logic [7:0] node_address_next;
    logic       accept;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        node_address_next = node_address_reg;
        if (cfg_valid)
            node_address_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_address_reg <= 8'd0;
        else
            node_address_reg <= node_address_next;
    end

    // Accept whenever the queue has room
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    // Classify; unused opcode is dropped here
    always_comb
    begin
        q_push          = 1'b0;
        q_cmd.kind      = CMD_RX;
        q_cmd.node_addr = node_address_reg;
        q_cmd.reg_byte  = {1'b0, in_data.reg_addr};
        q_cmd.data      = in_data.write_data;
        case (in_data.opcode)
            OP_WRITE:
            begin
                q_push         = accept;
                q_cmd.kind     = CMD_WRITE;
                q_cmd.reg_byte = {1'b0, in_data.reg_addr} | WRITE_FLAG;
            end
            OP_READ:
            begin
                q_push     = accept;
                q_cmd.kind = CMD_READ;
            end
            OP_RX:
            begin
                q_push     = accept;
                q_cmd.kind = CMD_RX;
                q_cmd.data = {24'd0, in_data.rx_byte};
            end
            OP_UNUSED:
            begin
                q_push = 1'b0;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/urde_queue.sv =====
// ----------------------------------------------------------------------------
// urde_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module urde_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  urde_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output urde_pkg::cmd_t    head_cmd,
    output urde_pkg::q_stat_t stat
);
    import urde_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.valid = (count_reg != 2'd0);
    assign stat.count = count_reg;

endmodule

// ===== rtl/core/urde_back.sv =====
// ----------------------------------------------------------------------------
// urde_back
// Executes queued commands: serializes request frames with CRC, one byte
// per cycle unless stalled; collects replies into a checked read result.
// ----------------------------------------------------------------------------
module urde_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  urde_pkg::cmd_t       head_cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output urde_pkg::out_item_t  out_data,
    output urde_pkg::back_stat_t stat
);
    import urde_pkg::*;

    logic [2:0]  frame_idx_reg;
    logic [2:0]  frame_idx_next;
    logic [7:0]  frame_crc_reg;
    logic [7:0]  frame_crc_next;
    logic [2:0]  reply_count_reg;
    logic [2:0]  reply_count_next;
    logic [7:0]  reply_crc_reg;
    logic [7:0]  reply_crc_next;
    logic [31:0] reply_data_reg;
    logic [31:0] reply_data_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    logic        out_free;
    logic        is_crc_byte;
    logic [7:0]  frame_byte;
    logic [7:0]  rx_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign rx_byte  = head_cmd.data[7:0];

    // Frame byte selection by position
    always_comb
    begin
        case (frame_idx_reg)
            3'd0:    frame_byte = SYNC_BYTE;
            3'd1:    frame_byte = head_cmd.node_addr;
            3'd2:    frame_byte = head_cmd.reg_byte;
            3'd3:    frame_byte = head_cmd.data[31:24];
            3'd4:    frame_byte = head_cmd.data[23:16];
            3'd5:    frame_byte = head_cmd.data[15:8];
            3'd6:    frame_byte = head_cmd.data[7:0];
            default: frame_byte = SYNC_BYTE;
        endcase
        if (head_cmd.kind == CMD_WRITE)
            is_crc_byte = (frame_idx_reg == WRITE_CRC_IDX);
        else
            is_crc_byte = (frame_idx_reg == READ_CRC_IDX);
    end

    // Command execution
    always_comb
    begin
        pop              = 1'b0;
        frame_idx_next   = frame_idx_reg;
        frame_crc_next   = frame_crc_reg;
        reply_count_next = reply_count_reg;
        reply_crc_next   = reply_crc_reg;
        reply_data_next  = reply_data_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;

        if (head_valid)
        begin
            case (head_cmd.kind)
                CMD_WRITE, CMD_READ:
                begin
                    if (out_free)
                    begin
                        out_valid_next            = 1'b1;
                        out_data_next.result_kind = KIND_TX;
                        out_data_next.read_data   = 32'd0;
                        out_data_next.crc_error   = 1'b0;
                        if (is_crc_byte)
                        begin
                            out_data_next.tx_byte = frame_crc_reg;
                            out_data_next.last    = 1'b1;
                            frame_idx_next        = 3'd0;
                            frame_crc_next        = 8'd0;
                            pop                   = 1'b1;
                            // A read restarts reply collection
                            if (head_cmd.kind == CMD_READ)
                            begin
                                reply_count_next = 3'd0;
                                reply_crc_next   = 8'd0;
                                reply_data_next  = 32'd0;
                            end
                        end
                        else
                        begin
                            out_data_next.tx_byte = frame_byte;
                            out_data_next.last    = 1'b0;
                            frame_idx_next        = frame_idx_reg + 3'd1;
                            frame_crc_next        = crc_feed(frame_crc_reg, frame_byte);
                        end
                    end
                end
                CMD_RX:
                begin
                    if (reply_count_reg != REPLY_LAST)
                    begin
                        // Intermediate reply byte, no result
                        pop              = 1'b1;
                        reply_crc_next   = crc_feed(reply_crc_reg, rx_byte);
                        reply_data_next  = {reply_data_reg[23:0], rx_byte};
                        reply_count_next = reply_count_reg + 3'd1;
                    end
                    else if (out_free)
                    begin
                        pop                       = 1'b1;
                        out_valid_next            = 1'b1;
                        out_data_next.result_kind = KIND_REPLY;
                        out_data_next.tx_byte     = 8'd0;
                        out_data_next.last        = 1'b1;
                        if (reply_crc_reg != rx_byte)
                        begin
                            out_data_next.read_data = ERROR_WORD;
                            out_data_next.crc_error = 1'b1;
                        end
                        else
                        begin
                            out_data_next.read_data = reply_data_reg;
                            out_data_next.crc_error = 1'b0;
                        end
                        reply_count_next = 3'd0;
                        reply_crc_next   = 8'd0;
                        reply_data_next  = 32'd0;
                    end
                end
                default:
                begin
                    pop = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_idx_reg   <= 3'd0;
            frame_crc_reg   <= 8'd0;
            reply_count_reg <= 3'd0;
            reply_crc_reg   <= 8'd0;
            reply_data_reg  <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_idx_reg   <= frame_idx_next;
            frame_crc_reg   <= frame_crc_next;
            reply_count_reg <= reply_count_next;
            reply_crc_reg   <= reply_crc_next;
            reply_data_reg  <= reply_data_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;
    assign stat.frame_idx    = frame_idx_reg;
    assign stat.reply_count  = reply_count_reg;

endmodule
